>>> sv/quaternion_rotate_vector_assert.svh
`ifndef QUATERNION_ROTATE_VECTOR_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define QRV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/qrv_pkg.sv
package qrv_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned WORD_WIDTH = 32;

  localparam int unsigned ANG_W    = 36;
  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned Q_W      = 64;
  localparam int unsigned NQ_W     = 31;
  localparam int unsigned P_W      = 62;
  localparam int unsigned NUM_W    = 33;
  localparam int unsigned DEN_W    = 32;
  localparam int unsigned QUO_W    = 31;
  localparam int unsigned ENT_W    = 32;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = 34'sd1073741824;
  localparam logic [QUO_W-1:0] ENT_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_DEGEN = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [19:0] angle;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    status_e            status;
  } rsp_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/qrv_cordic.sv
module qrv_cordic
  import qrv_pkg::*;
#(
  parameter int unsigned STEPS = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [CORDIC_W-1:0] h_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic                       valid_o,
  output logic signed [CORDIC_W-1:0] x_o,
  output logic signed [CORDIC_W-1:0] y_o,
  output logic [TAG_W-1:0]           tag_o
);

  logic [STEPS-1:0]           valid_q;
  logic signed [CORDIC_W-1:0] x_q [STEPS];
  logic signed [CORDIC_W-1:0] y_q [STEPS];
  logic signed [CORDIC_W-1:0] h_q [STEPS];
  logic [TAG_W-1:0]           tag_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STEPS-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic signed [CORDIC_W-1:0] x_in, y_in, h_in, dx, dy, at;
    logic [TAG_W-1:0]           t_in;

    if (g == 0) begin : g_first
      assign x_in = CORDIC_ONE;
      assign y_in = '0;
      assign h_in = h_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign y_in = y_q[g-1];
      assign h_in = h_q[g-1];
      assign t_in = tag_q[g-1];
    end

    assign at = CORDIC_W'(atan_q30(5'(g)));
    assign dx = y_in >>> g;
    assign dy = x_in >>> g;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[g] <= t_in;
        if (!h_in[CORDIC_W-1]) begin
          x_q[g] <= x_in - dx;
          y_q[g] <= y_in + dy;
          h_q[g] <= h_in - at;
        end else begin
          x_q[g] <= x_in + dx;
          y_q[g] <= y_in - dy;
          h_q[g] <= h_in + at;
        end
      end
    end
  end

  assign valid_o = valid_q[STEPS-1];
  assign x_o     = x_q[STEPS-1];
  assign y_o     = y_q[STEPS-1];
  assign tag_o   = tag_q[STEPS-1];

endmodule

>>> sv/qrv_div.sv
module qrv_div
  import qrv_pkg::*;
#(
  parameter int unsigned LANES = 9,
  parameter int unsigned TAG_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [NUM_W-1:0] num_i [LANES],
  input  logic [DEN_W-1:0]        den_i,
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    valid_o,
  output logic signed [ENT_W-1:0] ent_o [LANES],
  output logic [TAG_W-1:0]        tag_o
);

  // index 0 is the setup stage, 1..QUO_W one quotient bit each
  localparam int unsigned NS = QUO_W + 1;

  logic [NS-1:0]       valid_q;
  logic [DEN_W-1:0]    den_q [NS];
  logic [TAG_W-1:0]    tag_q [NS];
  logic [LANES-1:0]    neg_q [NS];
  logic [LANES-1:0]    ovf_q [NS];
  logic [DEN_W-1:0]    rem_q [NS][LANES];
  logic [QUO_W-1:0]    quo_q [NS][LANES];
  logic [LANES-1:0]    lsb_q;
  logic [NUM_W-1:0]    mag [LANES];
  logic                out_valid_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic signed [ENT_W-1:0] ent_q [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = num_i[l][NUM_W-1] ? NUM_W'(-num_i[l]) : NUM_W'(num_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= {valid_q[NS-2:0], valid_i};
      out_valid_q <= valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        neg_q[0][l] <= num_i[l][NUM_W-1];
        ovf_q[0][l] <= mag[l] >= {den_i, 1'b0};
        rem_q[0][l] <= mag[l][NUM_W-1:1];
        lsb_q[l]    <= mag[l][0];
        quo_q[0][l] <= '0;
      end
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_bit
    logic [DEN_W:0] r_in [LANES];
    logic [LANES-1:0] ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r_in[l] = {rem_q[g-1][l], (g == 1) ? lsb_q[l] : 1'b0};
        ge[l]   = r_in[l] >= {1'b0, den_q[g-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[g] <= den_q[g-1];
        tag_q[g] <= tag_q[g-1];
        neg_q[g] <= neg_q[g-1];
        ovf_q[g] <= ovf_q[g-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[g][l] <= ge[l] ? DEN_W'(r_in[l] - {1'b0, den_q[g-1]})
                               : r_in[l][DEN_W-1:0];
          quo_q[g][l] <= {quo_q[g-1][l][QUO_W-2:0], ge[l]};
        end
      end
    end
  end

  // clamp to +-1.0, then apply sign (truncation toward zero)
  always_ff @(posedge clk_i) begin
    logic [QUO_W-1:0]        mq;
    logic signed [ENT_W-1:0] e;
    if (en_i) begin
      out_tag_q <= tag_q[NS-1];
      for (int l = 0; l < LANES; l++) begin
        mq = (ovf_q[NS-1][l] || (quo_q[NS-1][l] >= ENT_ONE)) ? ENT_ONE : quo_q[NS-1][l];
        e  = ENT_W'(mq);
        ent_q[l] <= neg_q[NS-1][l] ? -e : e;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign tag_o   = out_tag_q;
  assign ent_o   = ent_q;

endmodule

>>> sv/quaternion_rotate_vector.sv
// channel | dir | valid       | stall       | request
// in      | in  | in_valid_i  | in_stall_o  | in_req_i  (req_t)
// out     | out | out_valid_o | out_stall_i | out_rsp_o (rsp_t)
//
// One request per cycle unless the output stalls; the pipeline runs through
// the CORDIC stages and the 31-bit pipelined divider.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// A stalled output freezes every stage at once; in_stall_o follows it.
`include "quaternion_rotate_vector_assert.svh"

module quaternion_rotate_vector
  import qrv_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  typedef struct packed {
    logic               fold;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } side_t;

  typedef struct packed {
    logic               degen;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } mv_t;

  localparam logic [6:0] NormLen = 7'd30;
  localparam logic signed [Q_W-1:0] SatHi = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [Q_W-1:0] SatLo = -(64'sd1 <<< (WORD_WIDTH - 1));

  logic adv;
  logic out_valid_q;
  rsp_t out_rsp_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage valids
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s6_valid_q, s7_valid_q, s8_valid_q, s9_valid_q, s10_valid_q;
  logic c_valid, d_valid;

  // angle wrap
  logic signed [ANG_W-1:0] h_in, h_wrap, s1_h_q;
  side_t s1_side_q;

  always_comb begin
    h_in = ANG_W'($signed(in_req_i.angle)) <<< (29 - FRAC_BITS);
    if (h_in > PI_Q30) begin
      h_wrap = h_in - TWO_PI_Q30;
    end else if (h_in < -PI_Q30) begin
      h_wrap = h_in + TWO_PI_Q30;
    end else begin
      h_wrap = h_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_h_q           <= h_wrap;
      s1_side_q.fold   <= 1'b0;
      s1_side_q.axis_x <= in_req_i.axis_x;
      s1_side_q.axis_y <= in_req_i.axis_y;
      s1_side_q.axis_z <= in_req_i.axis_z;
      s1_side_q.vec_x  <= in_req_i.vec_x;
      s1_side_q.vec_y  <= in_req_i.vec_y;
      s1_side_q.vec_z  <= in_req_i.vec_z;
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [ANG_W-1:0]    h_fold;
  logic                       fold;
  logic signed [CORDIC_W-1:0] s2_h_q;
  side_t                      s2_side_d;
  side_t                      s2_side_q;

  always_comb begin
    fold = 1'b1;
    if (s1_h_q > HALF_PI_Q30) begin
      h_fold = s1_h_q - PI_Q30;
    end else if (s1_h_q < -HALF_PI_Q30) begin
      h_fold = s1_h_q + PI_Q30;
    end else begin
      h_fold = s1_h_q;
      fold   = 1'b0;
    end
    s2_side_d      = s1_side_q;
    s2_side_d.fold = fold;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_h_q    <= h_fold[CORDIC_W-1:0];
      s2_side_q <= s2_side_d;
    end
  end

  logic signed [CORDIC_W-1:0] c_x, c_y;
  side_t                      c_side;

  qrv_cordic #(
    .STEPS (CORDIC_STEPS),
    .TAG_W ($bits(side_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_valid_q),
    .h_i     (s2_h_q),
    .tag_i   (s2_side_q),
    .valid_o (c_valid),
    .x_o     (c_x),
    .y_o     (c_y),
    .tag_o   (c_side)
  );

  // quaternion components
  logic signed [CORDIC_W-1:0] xf, yf;
  logic signed [31:0]         ys;
  logic signed [Q_W-1:0]      q0;
  logic signed [Q_W-1:0]      s3_q [4];
  mv_t                        s3_mv_q;

  always_comb begin
    xf = c_side.fold ? -c_x : c_x;
    yf = c_side.fold ? -c_y : c_y;
    ys = yf[31:0];
    q0 = Q_W'(xf);
    q0 = q0 <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q[0]       <= q0;
      s3_q[1]       <= c_side.axis_x * ys;
      s3_q[2]       <= c_side.axis_y * ys;
      s3_q[3]       <= c_side.axis_z * ys;
      s3_mv_q.degen <= 1'b0;
      s3_mv_q.vec_x <= c_side.vec_x;
      s3_mv_q.vec_y <= c_side.vec_y;
      s3_mv_q.vec_z <= c_side.vec_z;
    end
  end

  // magnitude OR: its top bit is the top bit of the largest magnitude
  logic [Q_W-1:0]        m_or;
  logic [Q_W-1:0]        s4_m_q;
  logic signed [Q_W-1:0] s4_q [4];
  mv_t                   s4_mv_q;

  always_comb begin
    m_or = '0;
    for (int i = 0; i < 4; i++) begin
      m_or = m_or | (s3_q[i][Q_W-1] ? Q_W'(-s3_q[i]) : Q_W'(s3_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_m_q  <= m_or;
      s4_q    <= s3_q;
      s4_mv_q <= s3_mv_q;
    end
  end

  // per-byte leading one
  logic [7:0]            nz;
  logic [2:0]            pos [8];
  logic [7:0]            s5_nz_q;
  logic [2:0]            s5_pos_q [8];
  logic signed [Q_W-1:0] s5_q [4];
  mv_t                   s5_mv_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nz[k]  = |s4_m_q[8*k +: 8];
      pos[k] = '0;
      for (int b = 0; b < 8; b++) begin
        if (s4_m_q[8*k + b]) begin
          pos[k] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_nz_q  <= nz;
      s5_pos_q <= pos;
      s5_q     <= s4_q;
      s5_mv_q  <= s4_mv_q;
    end
  end

  // shift amount
  logic [6:0]            len;
  logic                  right;
  logic [5:0]            sh;
  mv_t                   s6_mv_d;
  logic                  s6_right_q;
  logic [5:0]            s6_sh_q;
  logic signed [Q_W-1:0] s6_q [4];
  mv_t                   s6_mv_q;

  always_comb begin
    len = '0;
    for (int k = 0; k < 8; k++) begin
      if (s5_nz_q[k]) begin
        len = {1'b0, 3'(k), s5_pos_q[k]} + 7'd1;
      end
    end
    right = len > NormLen;
    sh    = right ? 6'(len - NormLen) : 6'(NormLen - len);
    s6_mv_d       = s5_mv_q;
    s6_mv_d.degen = ~|s5_nz_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_right_q <= right;
      s6_sh_q    <= sh;
      s6_q       <= s5_q;
      s6_mv_q    <= s6_mv_d;
    end
  end

  // normalize
  logic signed [Q_W-1:0]  t_sh [4];
  logic signed [NQ_W-1:0] s7_w_q [4];
  mv_t                    s7_mv_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_sh[i] = s6_right_q ? (s6_q[i] >>> s6_sh_q) : (s6_q[i] <<< s6_sh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s7_w_q[i] <= t_sh[i][NQ_W-1:0];
      end
      s7_mv_q <= s6_mv_q;
    end
  end

  // quadratic terms: w a b c = s7_w_q[0..3]
  logic signed [P_W-1:0] ww_q, aa_q, bb_q, cc_q, ab_q, ac_q, bc_q, wa_q, wb_q, wc_q;
  mv_t                   s8_mv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ww_q    <= s7_w_q[0] * s7_w_q[0];
      aa_q    <= s7_w_q[1] * s7_w_q[1];
      bb_q    <= s7_w_q[2] * s7_w_q[2];
      cc_q    <= s7_w_q[3] * s7_w_q[3];
      ab_q    <= s7_w_q[1] * s7_w_q[2];
      ac_q    <= s7_w_q[1] * s7_w_q[3];
      bc_q    <= s7_w_q[2] * s7_w_q[3];
      wa_q    <= s7_w_q[0] * s7_w_q[1];
      wb_q    <= s7_w_q[0] * s7_w_q[2];
      wc_q    <= s7_w_q[0] * s7_w_q[3];
      s8_mv_q <= s7_mv_q;
    end
  end

  // matrix numerators and norm, >> 31
  logic signed [Q_W-1:0]   nsum;
  logic signed [Q_W-1:0]   nm [9];
  logic signed [NUM_W-1:0] s9_num_q [9];
  logic [DEN_W-1:0]        s9_den_q;
  mv_t                     s9_mv_q;

  always_comb begin
    nsum  = ww_q + aa_q + bb_q + cc_q;
    nm[0] = ww_q + aa_q - bb_q - cc_q;
    nm[1] = ab_q - wc_q;
    nm[2] = ac_q + wb_q;
    nm[3] = ab_q + wc_q;
    nm[4] = ww_q - aa_q + bb_q - cc_q;
    nm[5] = bc_q - wa_q;
    nm[6] = ac_q - wb_q;
    nm[7] = bc_q + wa_q;
    nm[8] = ww_q - aa_q - bb_q + cc_q;
    for (int k = 1; k < 8; k++) begin
      if (k != 4) begin
        nm[k] = nm[k] <<< 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [Q_W-1:0] t;
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        t = nm[k] >>> 31;
        s9_num_q[k] <= t[NUM_W-1:0];
      end
      t = nsum >>> 31;
      s9_den_q <= t[DEN_W-1:0];
      s9_mv_q  <= s8_mv_q;
    end
  end

  logic signed [ENT_W-1:0] d_ent [9];
  mv_t                     d_mv;

  qrv_div #(
    .LANES (9),
    .TAG_W ($bits(mv_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s9_valid_q),
    .num_i   (s9_num_q),
    .den_i   (s9_den_q),
    .tag_i   (s9_mv_q),
    .valid_o (d_valid),
    .ent_o   (d_ent),
    .tag_o   (d_mv)
  );

  // matrix times vector
  logic signed [Q_W-1:0] s10_p_q [9];
  logic                  s10_degen_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s10_p_q[3*i]     <= d_ent[3*i]     * d_mv.vec_x;
        s10_p_q[3*i + 1] <= d_ent[3*i + 1] * d_mv.vec_y;
        s10_p_q[3*i + 2] <= d_ent[3*i + 2] * d_mv.vec_z;
      end
      s10_degen_q <= d_mv.degen;
    end
  end

  // sum, scale, saturate
  logic signed [Q_W-1:0] acc [3];
  logic [31:0]           rot [3];
  logic                  sat;
  rsp_t                  rsp_d;

  always_comb begin
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc[i] = (s10_p_q[3*i] + s10_p_q[3*i + 1] + s10_p_q[3*i + 2]) >>> 30;
      if (acc[i] > SatHi) begin
        acc[i] = SatHi;
        sat    = 1'b1;
      end else if (acc[i] < SatLo) begin
        acc[i] = SatLo;
        sat    = 1'b1;
      end
      rot[i] = acc[i][31:0];
    end
    if (s10_degen_q) begin
      rsp_d.rot_x  = '0;
      rsp_d.rot_y  = '0;
      rsp_d.rot_z  = '0;
      rsp_d.status = STATUS_DEGEN;
    end else begin
      rsp_d.rot_x  = rot[0];
      rsp_d.rot_y  = rot[1];
      rsp_d.rot_z  = rot[2];
      rsp_d.status = sat ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= c_valid;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= d_valid;
      out_valid_q <= s10_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `QRV_ASSERT_IMP(a_stall_src, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "stall not from held output")
  `QRV_ASSERT_NXT(a_freeze, in_stall_o, $stable(s1_valid_q) && $stable(s10_valid_q), "pipeline moved while stalled")
  `QRV_ASSERT_IMP(a_degen_zero, out_valid_o && (out_rsp_o.status == STATUS_DEGEN), (out_rsp_o.rot_x == 32'sd0) && (out_rsp_o.rot_y == 32'sd0) && (out_rsp_o.rot_z == 32'sd0), "degenerate result not zero")

endmodule

>>> bench/quaternion_rotate_vector_monitor.sv
module quaternion_rotate_vector_monitor
  import qrv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  rsp_t out_rsp_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LimQ30 = 64'sd1073741824;
  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TwoPiQ30 = 64'sd6746518852;

  rsp_t rotations_due[$];

  function automatic longint floor_shr(longint v, int s);
    if (s >= 63) return v < 0 ? -1 : 0;
    return v >>> s;
  endfunction

  function automatic longint matrix_entry(longint num, longint nr);
    longint e;
    e = floor_shr(num, 31) * LimQ30 / nr;
    if (e > LimQ30) e = LimQ30;
    if (e < -LimQ30) e = -LimQ30;
    return e;
  endfunction

  function automatic rsp_t rotate_vector(req_t rq);
    rsp_t rs;
    longint h, x, y, dx, dy, q[4], v[3], r[9], n, nr, s, w, a, b, c;
    longint ww, aa, bb, cc, lim;
    longint unsigned m, mq;
    int len;
    bit fold;
    fold = 0;
    x = LimQ30;
    y = 0;
    m = 0;
    len = 0;
    h = longint'(rq.angle) * 64'sd8192;
    h = h % TwoPiQ30;
    if (h > PiQ30) h -= TwoPiQ30;
    if (h < -PiQ30) h += TwoPiQ30;
    if (h > HalfPiQ30) begin h -= PiQ30; fold = 1; end
    if (h < -HalfPiQ30) begin h += PiQ30; fold = 1; end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (h >= 0) begin
        x -= dx; y += dy; h -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; h += longint'(atan_q30(5'(i)));
      end
    end
    if (fold) begin x = -x; y = -y; end
    q[0] = x * 64'sd65536;
    q[1] = longint'(rq.axis_x) * y;
    q[2] = longint'(rq.axis_y) * y;
    q[3] = longint'(rq.axis_z) * y;
    v[0] = longint'(rq.vec_x);
    v[1] = longint'(rq.vec_y);
    v[2] = longint'(rq.vec_z);
    for (int i = 0; i < 4; i++) begin
      mq = q[i] < 0 ? -q[i] : q[i];
      if (mq > m) m = mq;
    end
    if (m == 0) begin
      rs.rot_x = '0;
      rs.rot_y = '0;
      rs.rot_z = '0;
      rs.status = STATUS_DEGEN;
      return rs;
    end
    while (len < 64 && (m >> len) != 0) len++;
    for (int i = 0; i < 4; i++)
      q[i] = len > 30 ? floor_shr(q[i], len - 30) : q[i] <<< (30 - len);
    w = q[0]; a = q[1]; b = q[2]; c = q[3];
    ww = w * w; aa = a * a; bb = b * b; cc = c * c;
    n = ww + aa + bb + cc;
    nr = floor_shr(n, 31);
    r[0] = matrix_entry(ww + aa - bb - cc, nr);
    r[1] = matrix_entry(2 * (a * b - w * c), nr);
    r[2] = matrix_entry(2 * (a * c + w * b), nr);
    r[3] = matrix_entry(2 * (a * b + w * c), nr);
    r[4] = matrix_entry(ww - aa + bb - cc, nr);
    r[5] = matrix_entry(2 * (b * c - w * a), nr);
    r[6] = matrix_entry(2 * (a * c - w * b), nr);
    r[7] = matrix_entry(2 * (b * c + w * a), nr);
    r[8] = matrix_entry(ww - aa - bb + cc, nr);
    lim = 64'sd2147483647;
    rs.status = STATUS_OK;
    for (int i = 0; i < 3; i++) begin
      s = floor_shr(r[3*i] * v[0] + r[3*i+1] * v[1] + r[3*i+2] * v[2], 30);
      if (s > lim) begin s = lim; rs.status = STATUS_SAT; end
      if (s < -lim - 1) begin s = -lim - 1; rs.status = STATUS_SAT; end
      case (i)
        0: rs.rot_x = s[31:0];
        1: rs.rot_y = s[31:0];
        default: rs.rot_z = s[31:0];
      endcase
    end
    return rs;
  endfunction

  assign pending_o = rotations_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) rotations_due.push_back(rotate_vector(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (rotations_due.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = rotations_due.pop_front();
          if (exp_rsp.rot_x !== out_rsp_i.rot_x || exp_rsp.rot_y !== out_rsp_i.rot_y ||
              exp_rsp.rot_z !== out_rsp_i.rot_z || exp_rsp.status !== out_rsp_i.status) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_rsp, out_rsp_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/quaternion_rotate_vector_test.sv
module quaternion_rotate_vector_test;
  import qrv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  rsp_t out_rsp_o;
  int errors, pending;
  int send_idle = 34, recv_idle = 85;
  bit hold_off = 0;
  bit stim_done = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  quaternion_rotate_vector dut (.*);

  quaternion_rotate_vector_monitor monitor (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_rsp_i(out_rsp_o),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(int'($urandom_range(0, 131072)) - 65536);
      4: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [19:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 20'sd411775;
      1: return -20'sd411775;
      2: return '0;
      3: return 20'($urandom);
      default: return 20'(int'($urandom_range(0, 823550)) - 411775);
    endcase
  endfunction

  task automatic offer(req_t rq);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_req_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic rotate_random(int count);
    req_t rq;
    for (int k = 0; k < count; k++) begin
      rq.angle = rand_angle();
      rq.axis_x = rand_word();
      rq.axis_y = rand_word();
      rq.axis_z = rand_word();
      rq.vec_x = rand_word();
      rq.vec_y = rand_word();
      rq.vec_z = rand_word();
      if ($urandom_range(0, 9) == 0) begin
        rq.axis_x = '0; rq.axis_y = '0; rq.axis_z = '0;
      end
      offer(rq);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1;
    else out_stall_i <= $urandom_range(0, 99) < recv_idle;
  end

  initial begin
    req_t rq;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: angle extremes, degenerate, saturation, identity
    rq = '{20'sd0, 32'sd65536, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536};
    offer(rq);
    rq = '{20'sd0, 0, 0, 0, 32'sd65536, 0, 0};
    offer(rq);
    rq = '{20'sd102944, 0, 0, 0, 1, 2, 3};
    offer(rq);
    rq = '{20'sd205887, 0, 0, 0, 1, 2, 3};
    offer(rq);
    rq = '{20'sd411775, 0, 0, 32'sd65536, 32'sd65536, 0, 0};
    offer(rq);
    rq = '{-20'sd411775, 32'sd65536, 0, 0, 0, 32'sd65536, 0};
    offer(rq);
    rq = '{20'sd205887, 32'sd65536, 0, 0, 0, 32'sd65536, 0};
    offer(rq);
    rq = '{20'sd51472, 32'sd65536, 32'sd65536, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0};
    offer(rq);
    rq = '{20'sd51472, 0, 0, 32'sd65536, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    offer(rq);
    rq = '{20'h7ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1, -1};
    offer(rq);
    rq = '{20'h80000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, -1, 1};
    offer(rq);
    rq = '{20'sd103000, 1, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    offer(rq);
    rotate_random(330);
    send_idle = 85;
    recv_idle = 34;
    rotate_random(330);
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
      rotate_random(380);
    join
    in_valid_i <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("quaternion_rotate_vector_test: done, clean");
    else $display("quaternion_rotate_vector_test: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("quaternion_rotate_vector_test: done, errors");
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/qrv_pkg.sv
sv/qrv_cordic.sv
sv/qrv_div.sv
sv/quaternion_rotate_vector.sv
bench/quaternion_rotate_vector_monitor.sv
bench/quaternion_rotate_vector_test.sv
